@@ rtl/core/cls_pkg.sv @@
`default_nettype none
package cls_pkg;

  localparam int DEF_CAPACITY = 64;
  localparam int DATA_W       = 32;

  localparam logic [1:0] FUNC_APPEND = 2'd0;
  localparam logic [1:0] FUNC_DELETE = 2'd1;
  localparam logic [1:0] FUNC_READ   = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_EMPTY    = 2'd3;

  typedef struct packed {
    logic [1:0]               func;
    logic signed [DATA_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [DATA_W-1:0] data;
    logic                     last;
  } out_item_t;

  // result offered by the sequencer to the output register
  typedef struct packed {
    logic      valid;
    out_item_t item;
  } emit_t;

endpackage
`default_nettype wire

@@ rtl/core/cls_ram.sv @@
`default_nettype none
module cls_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/cls_seq.sv @@
`default_nettype none
module cls_seq #(
  parameter int CAPACITY = cls_pkg::DEF_CAPACITY,
  localparam int AW = $clog2(CAPACITY),
  localparam int CW = $clog2(CAPACITY + 1)
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire cls_pkg::in_item_t         in_item,
  input  wire logic                      can_emit,
  output cls_pkg::emit_t                 emit,
  output logic                           ram_wr_en,
  output logic [AW-1:0]                  ram_wr_addr,
  output logic [cls_pkg::DATA_W-1:0]     ram_wr_data,
  output logic                           ram_rd_en,
  output logic [AW-1:0]                  ram_rd_addr,
  input  wire logic [cls_pkg::DATA_W-1:0] ram_rd_data
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SRCH  = 3'd1;
  localparam logic [2:0] S_SHIFT = 3'd2;
  localparam logic [2:0] S_RDOUT = 3'd3;
  localparam logic [2:0] S_RESP  = 3'd4;

  logic [2:0]                   state_r, state_nxt;
  logic [CW-1:0]                count_r, count_nxt;
  logic [AW-1:0]                idx_r, idx_nxt;
  logic                         head_r, head_nxt;
  logic [cls_pkg::DATA_W-1:0]   val_r, val_nxt;
  logic [1:0]                   status_r, status_nxt;

  logic          full, empty, eq, idx_last, srch_hit, srch_head;
  logic [AW-1:0] cnt_last, idx_inc, pos, pos_inc;

  assign full     = (count_r == CW'(CAPACITY));
  assign empty    = (count_r == '0);
  assign cnt_last = AW'(count_r - CW'(1));
  assign idx_last = (idx_r == cnt_last);
  assign idx_inc  = idx_r + AW'(1);
  assign eq       = (ram_rd_data == val_r);
  // the head is checked only after the rest of the list has missed
  assign srch_hit  = eq && (idx_r != '0);
  assign srch_head = idx_last && ((idx_r == '0) ? eq : head_r);
  assign pos       = srch_hit ? idx_r : '0;
  assign pos_inc   = pos + AW'(1);

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    idx_nxt     = idx_r;
    head_nxt    = head_r;
    val_nxt     = val_r;
    status_nxt  = status_r;
    in_stall    = 1'b1;
    emit        = '0;
    ram_wr_en   = 1'b0;
    ram_wr_addr = '0;
    ram_wr_data = '0;
    ram_rd_en   = 1'b0;
    ram_rd_addr = '0;

    unique case (state_r)
      S_IDLE: begin
        // hold off the input while in reset
        in_stall = !rst_n;
        if (in_valid && rst_n) begin
          val_nxt = in_item.value;
          unique case (in_item.func)
            cls_pkg::FUNC_APPEND: begin
              state_nxt = S_RESP;
              if (full) begin
                status_nxt = cls_pkg::ST_FULL;
              end else begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = AW'(count_r);
                ram_wr_data = in_item.value;
                count_nxt   = count_r + CW'(1);
                status_nxt  = cls_pkg::ST_OK;
              end
            end
            cls_pkg::FUNC_DELETE, cls_pkg::FUNC_READ: begin
              if (empty) begin
                status_nxt = cls_pkg::ST_EMPTY;
                state_nxt  = S_RESP;
              end else begin
                ram_rd_en = 1'b1;
                idx_nxt   = '0;
                state_nxt = (in_item.func == cls_pkg::FUNC_DELETE) ? S_SRCH : S_RDOUT;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_SRCH: begin
        if (srch_hit || srch_head) begin
          if (pos == cnt_last) begin
            count_nxt  = count_r - CW'(1);
            status_nxt = cls_pkg::ST_OK;
            state_nxt  = S_RESP;
          end else begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = pos_inc;
            idx_nxt     = pos_inc;
            state_nxt   = S_SHIFT;
          end
        end else if (idx_last) begin
          status_nxt = cls_pkg::ST_NOTFOUND;
          state_nxt  = S_RESP;
        end else begin
          ram_rd_en   = 1'b1;
          ram_rd_addr = idx_inc;
          idx_nxt     = idx_inc;
          if (idx_r == '0) begin
            head_nxt = eq;
          end
        end
      end

      S_SHIFT: begin
        // move entry idx down one place while the next one is read
        ram_wr_en   = 1'b1;
        ram_wr_addr = idx_r - AW'(1);
        ram_wr_data = ram_rd_data;
        if (idx_last) begin
          count_nxt  = count_r - CW'(1);
          status_nxt = cls_pkg::ST_OK;
          state_nxt  = S_RESP;
        end else begin
          ram_rd_en   = 1'b1;
          ram_rd_addr = idx_inc;
          idx_nxt     = idx_inc;
        end
      end

      S_RDOUT: begin
        emit.valid       = 1'b1;
        emit.item.status = cls_pkg::ST_OK;
        emit.item.data   = ram_rd_data;
        emit.item.last   = idx_last;
        if (can_emit) begin
          if (idx_last) begin
            state_nxt = S_IDLE;
          end else begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = idx_inc;
            idx_nxt     = idx_inc;
          end
        end
      end

      S_RESP: begin
        emit.valid       = 1'b1;
        emit.item.status = status_r;
        emit.item.data   = '0;
        emit.item.last   = 1'b1;
        if (can_emit) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
    idx_r    <= idx_nxt;
    head_r   <= head_nxt;
    val_r    <= val_nxt;
    status_r <= status_nxt;
  end

endmodule
`default_nettype wire

@@ rtl/core/circular_list_store_top.sv @@
// append writes the ram on accept and then offers its result beat; delete searches, then
// shifts (one memory read per element for the search, one read and write per moved element)
// read out: after accept, one beat per cycle from the ram port while can_emit is high
// one item at a time; the next item is taken the cycle after its last result enters the
// output register
// reset: synchronous active-low rst_n empties the store; no memory clearing pass
`default_nettype none
module circular_list_store_top #(
  parameter int CAPACITY = cls_pkg::DEF_CAPACITY
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire cls_pkg::in_item_t  in_item,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output cls_pkg::out_item_t      out_item
);

  localparam int AW = $clog2(CAPACITY);

  logic                       ram_wr_en, ram_rd_en, can_emit;
  logic [AW-1:0]              ram_wr_addr, ram_rd_addr;
  logic [cls_pkg::DATA_W-1:0] ram_wr_data, ram_rd_data;
  cls_pkg::emit_t             emit;

  logic               out_valid_r, out_valid_nxt;
  cls_pkg::out_item_t out_item_r;

  cls_ram #(
    .WIDTH (cls_pkg::DATA_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  cls_seq #(
    .CAPACITY (CAPACITY)
  ) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_item     (in_item),
    .can_emit    (can_emit),
    .emit        (emit),
    .ram_wr_en   (ram_wr_en),
    .ram_wr_addr (ram_wr_addr),
    .ram_wr_data (ram_wr_data),
    .ram_rd_en   (ram_rd_en),
    .ram_rd_addr (ram_rd_addr),
    .ram_rd_data (ram_rd_data)
  );

  // output register takes a new beat when empty or being drained
  assign can_emit      = !out_valid_r || !out_stall;
  assign out_valid_nxt = emit.valid ? 1'b1 : (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    if (emit.valid && can_emit) begin
      out_item_r <= emit.item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
`default_nettype wire
